// ===== sv/tpfq_pkg.sv =====
// ----------------------------------------------------------------------------
// tpfq_pkg
// Types and codes shared by the two-priority frame queue modules.
// ----------------------------------------------------------------------------
package tpfq_pkg;

  localparam int ID_W    = 29;
  localparam int PAY_W   = 64;
  localparam int FRAME_W = ID_W + PAY_W;
  localparam int SRC_W   = 2;

  // operation codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // push targets
  localparam logic PRIO_URGENT = 1'b0;
  localparam logic PRIO_NORMAL = 1'b1;

  // pop sources
  localparam logic [SRC_W-1:0] SRC_NONE   = 2'd0;
  localparam logic [SRC_W-1:0] SRC_URGENT = 2'd1;
  localparam logic [SRC_W-1:0] SRC_NORMAL = 2'd2;

  typedef struct packed {
    logic             func;
    logic             priority_req;
    logic [ID_W-1:0]  frame_id;
    logic [PAY_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [SRC_W-1:0] source;
    logic [ID_W-1:0]  out_id;
    logic [PAY_W-1:0] out_payload;
    logic             dropped;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;  // take the item on the input this cycle
    logic emit;    // present the result of the last item
  } ctrl_cmd_t;

endpackage

// ===== sv/two_priority_frame_queue.sv =====
// ----------------------------------------------------------------------------
// two_priority_frame_queue
// Strict-priority pair of CAN frame queues with overflow drop of the oldest.
// ----------------------------------------------------------------------------
// Each item is taken on start when busy is low; busy is high for the
// following cycle, and in that cycle out_strobe marks the item's
// result. That cycle is the registered read of the frame store RAMs.
// Every item, push or pop, gives one result; the receiver cannot stall it,
// so out_item must be captured in the strobe cycle. Each ring holds DEPTH-1
// frames; a push into a full ring discards its oldest frame and sets dropped.
// No clearing pass is needed after reset.
module two_priority_frame_queue
  import tpfq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  ctrl_cmd_t cmd;

  tpfq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  tpfq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

  assign out_strobe = cmd.emit;

endmodule

// ===== sv/tpfq_ram.sv =====
// ----------------------------------------------------------------------------
// tpfq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/tpfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpfq_ctrl
// Command sequencer: accepts an item, then presents its result in the
// S_DONE state while the frame store read completes.
// ----------------------------------------------------------------------------
module tpfq_ctrl
  import tpfq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DONE = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r == S_DONE);
  assign cmd.accept = (state_r == S_IDLE) && start;
  assign cmd.emit   = (state_r == S_DONE);

endmodule

// ===== sv/tpfq_dp.sv =====
// ----------------------------------------------------------------------------
// tpfq_dp
// Ring pointers, frame stores and result formatting for the urgent and
// normal queues.
// ----------------------------------------------------------------------------
module tpfq_dp
  import tpfq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_cmd_t cmd,
  input  in_item_t  in_item,
  output out_item_t out_item
);

  localparam int          AW   = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] u_head_r, u_head_nxt, u_tail_r, u_tail_nxt;
  logic [AW-1:0] n_head_r, n_head_nxt, n_tail_r, n_tail_nxt;
  logic [SRC_W-1:0] src_r, src_nxt;
  logic             drop_r, drop_nxt;

  logic [AW-1:0] u_head_inc, u_tail_inc, n_head_inc, n_tail_inc;
  logic          u_empty, n_empty;
  logic          is_push, is_pop;
  logic          u_we, n_we;

  logic [FRAME_W-1:0] wframe;
  logic [FRAME_W-1:0] u_rdata, n_rdata;

  assign u_head_inc = (u_head_r == LAST) ? '0 : u_head_r + 1'b1;
  assign u_tail_inc = (u_tail_r == LAST) ? '0 : u_tail_r + 1'b1;
  assign n_head_inc = (n_head_r == LAST) ? '0 : n_head_r + 1'b1;
  assign n_tail_inc = (n_tail_r == LAST) ? '0 : n_tail_r + 1'b1;

  assign u_empty = (u_head_r == u_tail_r);
  assign n_empty = (n_head_r == n_tail_r);

  assign is_push = cmd.accept && (in_item.func == FUNC_PUSH);
  assign is_pop  = cmd.accept && (in_item.func == FUNC_POP);
  assign u_we    = is_push && (in_item.priority_req == PRIO_URGENT);
  assign n_we    = is_push && (in_item.priority_req == PRIO_NORMAL);
  assign wframe  = {in_item.frame_id, in_item.payload};

  always_comb begin
    u_head_nxt = u_head_r;
    u_tail_nxt = u_tail_r;
    n_head_nxt = n_head_r;
    n_tail_nxt = n_tail_r;
    src_nxt    = src_r;
    drop_nxt   = drop_r;
    if (u_we) begin
      u_tail_nxt = u_tail_inc;
      src_nxt    = SRC_NONE;
      drop_nxt   = (u_tail_inc == u_head_r);
      // full ring: oldest frame is discarded by advancing the head
      if (u_tail_inc == u_head_r) begin
        u_head_nxt = u_head_inc;
      end
    end else if (n_we) begin
      n_tail_nxt = n_tail_inc;
      src_nxt    = SRC_NONE;
      drop_nxt   = (n_tail_inc == n_head_r);
      if (n_tail_inc == n_head_r) begin
        n_head_nxt = n_head_inc;
      end
    end else if (is_pop) begin
      drop_nxt = 1'b0;
      priority if (!u_empty) begin
        src_nxt    = SRC_URGENT;
        u_head_nxt = u_head_inc;
      end else if (!n_empty) begin
        src_nxt    = SRC_NORMAL;
        n_head_nxt = n_head_inc;
      end else begin
        src_nxt = SRC_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_head_r <= '0;
      u_tail_r <= '0;
      n_head_r <= '0;
      n_tail_r <= '0;
    end else begin
      u_head_r <= u_head_nxt;
      u_tail_r <= u_tail_nxt;
      n_head_r <= n_head_nxt;
      n_tail_r <= n_tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r  <= src_nxt;
    drop_r <= drop_nxt;
  end

  // both stores are read at their heads; the result picks one
  tpfq_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (DEPTH)
  ) u_urgent_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_tail_r),
    .wdata (wframe),
    .re    (is_pop),
    .raddr (u_head_r),
    .rdata (u_rdata)
  );

  tpfq_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (DEPTH)
  ) u_normal_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_tail_r),
    .wdata (wframe),
    .re    (is_pop),
    .raddr (n_head_r),
    .rdata (n_rdata)
  );

  always_comb begin
    out_item             = '0;
    out_item.source      = src_r;
    out_item.dropped     = drop_r;
    unique case (src_r)
      SRC_URGENT: begin
        out_item.out_id      = u_rdata[FRAME_W-1 -: ID_W];
        out_item.out_payload = u_rdata[PAY_W-1:0];
      end
      SRC_NORMAL: begin
        out_item.out_id      = n_rdata[FRAME_W-1 -: ID_W];
        out_item.out_payload = n_rdata[PAY_W-1:0];
      end
      default: begin
        out_item.out_id      = '0;
        out_item.out_payload = '0;
      end
    endcase
    if (!cmd.emit) begin
      out_item = '0;
    end
  end

endmodule
